@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check with a generic message
`define ASSERT_BLG(lbl, prop) \
  `ASSERT_CLK(lbl, prop, "bilinear lookup check failed")

`endif

@@ rtl/blg_pkg.sv @@
package blg_pkg;

  // Grid size defaults
  localparam int unsigned DIST_POINTS_DEF = 16;
  localparam int unsigned VEL_POINTS_DEF  = 16;

  // Field widths
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned VCFG_W  = 15;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DIV_W   = POS_W + FRAC_W;

  // Register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_DIST_ORIGIN = 3'd0,
    REG_DIST_STEP   = 3'd1,
    REG_DIST_LIMIT  = 3'd2,
    REG_VEL_STEP    = 3'd3,
    REG_VEL_FLOOR   = 3'd4,
    REG_VEL_LIMIT   = 3'd5
  } cfg_reg_e;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register reset values
  localparam logic [POS_W-1:0]  DIST_ORIGIN_RST = 16'd0;
  localparam logic [POS_W-1:0]  DIST_STEP_RST   = 16'd256;
  localparam logic [POS_W-1:0]  DIST_LIMIT_RST  = 16'd3840;
  localparam logic [VCFG_W-1:0] VEL_STEP_RST    = 15'd64;
  localparam logic [VCFG_W-1:0] VEL_FLOOR_RST   = 15'd0;
  localparam logic [VCFG_W-1:0] VEL_LIMIT_RST   = 15'd960;

  // Fraction of 1.0
  localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

endpackage

@@ rtl/bilinear_grid_lookup_top.sv @@
// Queries reach lead_value_o via entry, divider, lookup, multiply and output registers.
// Throughput: one request per cycle outside a hold; the 32-stage radix-2 dividers
//   and the banked grid RAMs (four banks, one read each per cycle) are fully pipelined.
// The whole pipeline holds while a result waits under out_stall_i.
// Reset loads the configuration registers with their reset values and clears all valid
//   flags; grid contents are undefined until loaded.
`include "assert_macros.svh"

module bilinear_grid_lookup_top #(
  parameter int unsigned DIST_POINTS = blg_pkg::DIST_POINTS_DEF,
  parameter int unsigned VEL_POINTS  = blg_pkg::VEL_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [blg_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [blg_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [blg_pkg::IDX_W-1:0]   row_index_i,
  input  logic [blg_pkg::IDX_W-1:0]   col_index_i,
  input  logic signed [blg_pkg::VAL_W-1:0] entry_value_i,
  input  logic [blg_pkg::POS_W-1:0]   distance_i,
  input  logic signed [blg_pkg::POS_W-1:0] velocity_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [blg_pkg::VAL_W-1:0] lead_value_o
);

  import blg_pkg::*;

  localparam int unsigned IW    = $clog2(DIST_POINTS);
  localparam int unsigned JW    = $clog2(VEL_POINTS);
  localparam int unsigned DH    = (DIST_POINTS + 1) / 2;
  localparam int unsigned VH    = (VEL_POINTS + 1) / 2;
  localparam int unsigned DEPTH = DH * VH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NST   = DIV_W;

  // ---------------- configuration registers ----------------
  logic [POS_W-1:0]  dist_origin_q, dist_step_q, dist_limit_q;
  logic [VCFG_W-1:0] vel_step_q, vel_floor_q, vel_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_origin_q <= DIST_ORIGIN_RST;
      dist_step_q   <= DIST_STEP_RST;
      dist_limit_q  <= DIST_LIMIT_RST;
      vel_step_q    <= VEL_STEP_RST;
      vel_floor_q   <= VEL_FLOOR_RST;
      vel_limit_q   <= VEL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DIST_ORIGIN: dist_origin_q <= cfg_data_i;
        REG_DIST_STEP:   dist_step_q   <= cfg_data_i;
        REG_DIST_LIMIT:  dist_limit_q  <= cfg_data_i;
        REG_VEL_STEP:    vel_step_q    <= cfg_data_i[VCFG_W-1:0];
        REG_VEL_FLOOR:   vel_floor_q   <= cfg_data_i[VCFG_W-1:0];
        REG_VEL_LIMIT:   vel_limit_q   <= cfg_data_i[VCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic out_valid_q;
  logic hold, adv, accept;

  assign hold       = out_valid_q & out_stall_i;
  assign adv        = ~hold;
  assign in_stall_o = hold;
  assign accept     = in_valid_i & adv;

  // ---------------- front end: abs, clamp, offset ----------------
  logic [POS_W-1:0] d_clamp, d_pos, v_abs, v_floor, v_limit, v_clamp;
  logic [POS_W-1:0] dstep_half, vstep_half;
  logic [DIV_W-1:0] d_dvd, v_dvd;

  always_comb begin
    if (distance_i < dist_origin_q) begin
      d_clamp = dist_origin_q;
    end else if (distance_i > dist_limit_q) begin
      d_clamp = dist_limit_q;
    end else begin
      d_clamp = distance_i;
    end
    d_pos = (d_clamp > dist_origin_q) ? (d_clamp - dist_origin_q) : '0;

    v_abs   = velocity_i[POS_W-1] ? (~velocity_i + 16'd1) : velocity_i;
    v_floor = {1'b0, vel_floor_q};
    v_limit = {1'b0, vel_limit_q};
    if (v_abs < v_floor) begin
      v_clamp = v_floor;
    end else if (v_abs > v_limit) begin
      v_clamp = v_limit;
    end else begin
      v_clamp = v_abs;
    end

    // dividend carries the half-step rounding bias of the fraction
    dstep_half = dist_step_q >> 1;
    vstep_half = {1'b0, vel_step_q} >> 1;
    d_dvd      = {d_pos, 16'h0} + {16'h0, dstep_half};
    v_dvd      = {v_clamp, 16'h0} + {16'h0, vstep_half};
  end

  // ---------------- divider pipeline ----------------
  logic             st_vld_q  [NST+1];
  logic             st_qry_q  [NST+1];
  logic [IDX_W-1:0] st_row_q  [NST+1];
  logic [IDX_W-1:0] st_col_q  [NST+1];
  logic [VAL_W-1:0] st_val_q  [NST+1];
  logic [POS_W-1:0] st_drem_q [NST+1];
  logic [DIV_W-1:0] st_ddvd_q [NST+1];
  logic [POS_W-1:0] st_vrem_q [NST+1];
  logic [DIV_W-1:0] st_vdvd_q [NST+1];

  logic [POS_W-1:0] vstep_ext;
  assign vstep_ext = {1'b0, vel_step_q};

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q[0] <= 1'b0;
    end else if (adv) begin
      st_vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_qry_q[0]  <= req_type_i;
      st_row_q[0]  <= row_index_i;
      st_col_q[0]  <= col_index_i;
      st_val_q[0]  <= entry_value_i;
      st_drem_q[0] <= '0;
      st_ddvd_q[0] <= d_dvd;
      st_vrem_q[0] <= '0;
      st_vdvd_q[0] <= v_dvd;
    end
  end

  // one quotient bit per stage on each axis
  for (genvar s = 0; s < NST; s++) begin : g_div
    logic [POS_W:0]   d_trial, v_trial;
    logic             d_ge, v_ge;

    assign d_trial = {st_drem_q[s], st_ddvd_q[s][DIV_W-1]};
    assign v_trial = {st_vrem_q[s], st_vdvd_q[s][DIV_W-1]};
    assign d_ge    = d_trial >= {1'b0, dist_step_q};
    assign v_ge    = v_trial >= {1'b0, vstep_ext};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        st_vld_q[s+1] <= st_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_qry_q[s+1]  <= st_qry_q[s];
        st_row_q[s+1]  <= st_row_q[s];
        st_col_q[s+1]  <= st_col_q[s];
        st_val_q[s+1]  <= st_val_q[s];
        st_drem_q[s+1] <= d_ge ? POS_W'(d_trial - {1'b0, dist_step_q})
                               : d_trial[POS_W-1:0];
        st_vrem_q[s+1] <= v_ge ? POS_W'(v_trial - {1'b0, vstep_ext})
                               : v_trial[POS_W-1:0];
        st_ddvd_q[s+1] <= {st_ddvd_q[s][DIV_W-2:0], d_ge};
        st_vdvd_q[s+1] <= {st_vdvd_q[s][DIV_W-2:0], v_ge};
      end
    end
  end

  // ---------------- locate cell, access grid banks ----------------
  logic [POS_W-1:0]  d_k, v_k;
  logic [IW-1:0]     cell_i;
  logic [JW-1:0]     cell_j;
  logic [FRAC_W:0]   frac_t, frac_u;

  always_comb begin
    d_k = st_ddvd_q[NST][DIV_W-1:FRAC_W];
    v_k = st_vdvd_q[NST][DIV_W-1:FRAC_W];
    if (dist_step_q == '0) begin
      cell_i = '0;
      frac_t = '0;
    end else if (d_k >= POS_W'(DIST_POINTS - 1)) begin
      cell_i = IW'(DIST_POINTS - 2);
      frac_t = FRAC_ONE;
    end else begin
      cell_i = d_k[IW-1:0];
      frac_t = {1'b0, st_ddvd_q[NST][FRAC_W-1:0]};
    end
    if (vel_step_q == '0) begin
      cell_j = '0;
      frac_u = '0;
    end else if (v_k >= POS_W'(VEL_POINTS - 1)) begin
      cell_j = JW'(VEL_POINTS - 2);
      frac_u = FRAC_ONE;
    end else begin
      cell_j = v_k[JW-1:0];
      frac_u = {1'b0, st_vdvd_q[NST][FRAC_W-1:0]};
    end
  end

  // load target: bank by row/col parity
  logic             ld_ok, ld_we;
  logic [1:0]       ld_bank;
  logic [POS_W-1:0] ld_lin;
  logic [AW-1:0]    ld_addr;

  always_comb begin
    ld_ok   = ({3'b0, st_row_q[NST]} < 7'(DIST_POINTS)) &&
              ({3'b0, st_col_q[NST]} < 7'(VEL_POINTS));
    ld_we   = adv && st_vld_q[NST] && (st_qry_q[NST] == REQ_LOAD) && ld_ok;
    ld_bank = {st_row_q[NST][0], st_col_q[NST][0]};
    ld_lin  = POS_W'((POS_W'(st_row_q[NST]) >> 1) * POS_W'(VH))
            + (POS_W'(st_col_q[NST]) >> 1);
    ld_addr = ld_lin[AW-1:0];
  end

  logic [VAL_W-1:0] bank_rd [4];

  // bank b = {row parity, col parity}; each corner of a cell sits in its own bank
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);
    logic [IW:0]      r_idx;
    logic [JW:0]      c_idx;
    logic [POS_W-1:0] rd_lin;
    logic [AW-1:0]    rd_addr;

    always_comb begin
      r_idx   = (cell_i[0] == RP) ? {1'b0, cell_i} : ({1'b0, cell_i} + 1'b1);
      c_idx   = (cell_j[0] == CP) ? {1'b0, cell_j} : ({1'b0, cell_j} + 1'b1);
      rd_lin  = POS_W'((POS_W'(r_idx) >> 1) * POS_W'(VH)) + (POS_W'(c_idx) >> 1);
      rd_addr = rd_lin[AW-1:0];
    end

    blg_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ld_we && (ld_bank == 2'(b))),
      .waddr_i (ld_addr),
      .wdata_i (st_val_q[NST]),
      .re_i    (adv),
      .raddr_i (rd_addr),
      .rdata_o (bank_rd[b])
    );
  end

  // lookup stage registers (aligned with bank read data)
  logic            lk_vld_q, lk_qry_q, lk_i0_q, lk_j0_q;
  logic [FRAC_W:0] lk_t_q, lk_u_q;
  logic [IW-1:0]   lk_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_vld_q <= 1'b0;
    end else if (adv) begin
      lk_vld_q <= st_vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lk_qry_q <= st_qry_q[NST];
      lk_i_q   <= cell_i;
      lk_i0_q  <= cell_i[0];
      lk_j0_q  <= cell_j[0];
      lk_t_q   <= frac_t;
      lk_u_q   <= frac_u;
    end
  end

  // ---------------- interpolate along distance ----------------
  logic signed [VAL_W-1:0] z00, z10, z01, z11;
  logic signed [FRAC_W+1:0] w_t, w_omt;
  logic signed [VAL_W+FRAC_W+2:0] a_d, b_d;

  always_comb begin
    z00   = bank_rd[{lk_i0_q, lk_j0_q}];
    z10   = bank_rd[{~lk_i0_q, lk_j0_q}];
    z01   = bank_rd[{lk_i0_q, ~lk_j0_q}];
    z11   = bank_rd[{~lk_i0_q, ~lk_j0_q}];
    w_t   = signed'({1'b0, lk_t_q});
    w_omt = signed'({1'b0, FRAC_ONE - lk_t_q});
    a_d   = (VAL_W+FRAC_W+3)'(z00 * w_omt) + (VAL_W+FRAC_W+3)'(z10 * w_t);
    b_d   = (VAL_W+FRAC_W+3)'(z01 * w_omt) + (VAL_W+FRAC_W+3)'(z11 * w_t);
  end

  logic                           m1_vld_q, m1_qry_q;
  logic signed [VAL_W+FRAC_W+2:0] m1_a_q, m1_b_q;
  logic [FRAC_W:0]                m1_u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= lk_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_qry_q <= lk_qry_q;
      m1_a_q   <= a_d;
      m1_b_q   <= b_d;
      m1_u_q   <= lk_u_q;
    end
  end

  // ---------------- interpolate along velocity ----------------
  localparam int unsigned PW = VAL_W + 2 * FRAC_W + 5;

  logic signed [FRAC_W+1:0] w_u, w_omu;
  logic signed [PW-1:0]     pa_d, pb_d;

  always_comb begin
    w_u   = signed'({1'b0, m1_u_q});
    w_omu = signed'({1'b0, FRAC_ONE - m1_u_q});
    pa_d  = PW'(m1_a_q * w_omu);
    pb_d  = PW'(m1_b_q * w_u);
  end

  logic                 m2_vld_q, m2_qry_q;
  logic signed [PW-1:0] m2_pa_q, m2_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (adv) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_qry_q <= m1_qry_q;
      m2_pa_q  <= m2_pa_d_hold(pa_d);
      m2_pb_q  <= pb_d;
    end
  end

  function automatic logic signed [PW-1:0] m2_pa_d_hold(input logic signed [PW-1:0] x);
    return x;
  endfunction

  // ---------------- round, saturate, output register ----------------
  logic signed [PW:0]        sum_d;
  logic signed [PW-32:0]     res_d;
  logic signed [VAL_W-1:0]   lead_d;

  always_comb begin
    sum_d = (PW+1)'(m2_pa_q) + (PW+1)'(m2_pb_q) + (PW+1)'(64'sd2147483648);
    res_d = sum_d[PW:32];
    if (res_d > (PW-31)'(32767)) begin
      lead_d = 16'sh7FFF;
    end else if (res_d < -(PW-31)'(32768)) begin
      lead_d = -16'sh8000;
    end else begin
      lead_d = res_d[VAL_W-1:0];
    end
  end

  logic signed [VAL_W-1:0] lead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m2_vld_q && (m2_qry_q == REQ_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lead_q <= lead_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lead_value_o = lead_q;

  // ---------------- assertions ----------------
  `ASSERT_BLG(a_out_from_query,
              $rose(out_valid_q) |-> $past(m2_vld_q && (m2_qry_q == REQ_QUERY)))
  `ASSERT_BLG(a_frac_range, lk_vld_q |-> (lk_t_q <= FRAC_ONE && lk_u_q <= FRAC_ONE))
  `ASSERT_BLG(a_cell_range, lk_vld_q |-> ({1'b0, lk_i_q} <= (IW+1)'(DIST_POINTS - 2)))

endmodule

@@ rtl/blg_ram.sv @@
module blg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/bilinear_grid_lookup_top_test.sv @@
module bilinear_grid_lookup_top_test;
  import blg_pkg::*;

  localparam int NPTS = 16;
  localparam int UNITY = 65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = REQ_LOAD;
  logic [IDX_W-1:0] row_index_i = '0;
  logic [IDX_W-1:0] col_index_i = '0;
  logic signed [VAL_W-1:0] entry_value_i = '0;
  logic [POS_W-1:0] distance_i = '0;
  logic signed [POS_W-1:0] velocity_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] lead_value_o;

  bilinear_grid_lookup_top DUT (.*);

  // Shadow of grid contents and registers
  logic signed [VAL_W-1:0] grid_shadow [NPTS*NPTS];
  int unsigned org_q, dstep_q, dlim_q, vstep_q, vfloor_q, vlim_q;

  logic signed [VAL_W-1:0] lead_queue [$];
  int fails = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  typedef struct {
    logic rtype;
    logic [3:0] row;
    logic [3:0] col;
    logic signed [15:0] val;
    logic [15:0] dist_val;
    logic signed [15:0] vel;
    bit typed;
    logic signed [15:0] lead;
  } stim_row_t;

  // Directed stimulus: corner loads, then queries on those cells only
  stim_row_t directed [] = '{
    '{REQ_LOAD, 0, 0, 16'sh7fff, 0, 0, 0, 0},
    '{REQ_LOAD, 1, 0, -16'sh8000, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 1, 16'sh0100, 0, 0, 0, 0},
    '{REQ_LOAD, 1, 1, -16'sh0001, 0, 0, 0, 0},
    '{REQ_LOAD, 14, 14, 16'sh0064, 0, 0, 0, 0},
    '{REQ_LOAD, 15, 14, -16'sh00c8, 0, 0, 0, 0},
    '{REQ_LOAD, 14, 15, 16'sh012c, 0, 0, 0, 0},
    '{REQ_LOAD, 15, 15, -16'sh8000, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 14, 16'sh0000, 0, 0, 0, 0},
    '{REQ_LOAD, 1, 14, 16'sh0005, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 15, 16'sh1234, 0, 0, 0, 0},
    '{REQ_LOAD, 1, 15, -16'sh1234, 0, 0, 0, 0},
    // grid origin gives the first entry exactly
    '{REQ_QUERY, 0, 0, 0, 16'h0000, 16'sh0000, 1, 16'sh7fff},
    // both axes past the end: far corner
    '{REQ_QUERY, 0, 0, 0, 16'hffff, -16'sh8000, 1, -16'sh8000},
    // velocity past the end at first distance point
    '{REQ_QUERY, 0, 0, 0, 16'h0000, 16'sh7fff, 1, 16'sh1234},
    '{REQ_QUERY, 0, 0, 0, 16'h0080, 16'sh0020, 0, 0},
    '{REQ_QUERY, 0, 0, 0, 16'h00ff, -16'sh0021, 0, 0},
    '{REQ_QUERY, 0, 0, 0, 16'h0eff, 16'sh03bf, 0, 0},
    '{REQ_QUERY, 0, 0, 0, 16'h0064, -16'sh0001, 0, 0}
  };

  // Register settings per phase: origin, dstep, dlimit, vstep, vfloor, vlimit
  int unsigned reg_sets [6][6] = '{
    '{0, 256, 3840, 64, 0, 960},
    '{1000, 300, 6000, 100, 50, 1600},
    '{0, 1, 65535, 1, 0, 32767},
    '{65535, 65535, 0, 32767, 32767, 0},
    '{3000, 0, 1000, 0, 10, 500},
    '{200, 4096, 65535, 2048, 0, 32767}
  };

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Cell and 16-bit fraction along one axis
  function automatic void find_cell(input int unsigned pos, input int unsigned step,
                                    output int unsigned cell_idx, output int unsigned frac);
    int unsigned k;
    if (step == 0) begin
      cell_idx = 0;
      frac = 0;
    end else begin
      k = pos / step;
      if (k >= NPTS - 1) begin
        cell_idx = NPTS - 2;
        frac = UNITY;
      end else begin
        cell_idx = k;
        frac = int'(((longint'(pos - k * step) << 16) + longint'(step >> 1))
                    / longint'(step));
      end
    end
  endfunction

  function automatic logic signed [15:0] predict_lead(logic [15:0] dist_val,
                                                      logic signed [15:0] vel);
    int d, v;
    int unsigned dpos, i, j, t, u;
    longint sum, res;
    d = int'(dist_val);
    if (d < int'(org_q)) d = org_q;
    else if (d > int'(dlim_q)) d = dlim_q;
    v = int'(vel);
    if (v < 0) v = -v;
    if (v < int'(vfloor_q)) v = vfloor_q;
    else if (v > int'(vlim_q)) v = vlim_q;
    dpos = (d > int'(org_q)) ? d - org_q : 0;
    find_cell(dpos, dstep_q, i, t);
    find_cell(v, vstep_q, j, u);
    sum = longint'(grid_shadow[i*NPTS+j]) * (longint'(UNITY - t) * longint'(UNITY - u))
        + longint'(grid_shadow[(i+1)*NPTS+j]) * (longint'(t) * longint'(UNITY - u))
        + longint'(grid_shadow[i*NPTS+j+1]) * (longint'(UNITY - t) * longint'(u))
        + longint'(grid_shadow[(i+1)*NPTS+j+1]) * (longint'(t) * longint'(u));
    res = (sum + (64'sd1 <<< 31)) >>> 32;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  // One register write; the caller drops the enable after the last one
  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[15:0];
    @(posedge clk_i);
    case (idx)
      REG_DIST_ORIGIN: org_q = data & 16'hffff;
      REG_DIST_STEP:   dstep_q = data & 16'hffff;
      REG_DIST_LIMIT:  dlim_q = data & 16'hffff;
      REG_VEL_STEP:    vstep_q = data & 15'h7fff;
      REG_VEL_FLOOR:   vfloor_q = data & 15'h7fff;
      REG_VEL_LIMIT:   vlim_q = data & 15'h7fff;
      default: ;
    endcase
  endtask

  // Sender holds off until every query result is back and the pipe is empty
  task automatic drain;
    in_valid_i <= 1'b0;
    while (lead_queue.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  // Present one request; on acceptance update the shadow or queue the result
  task automatic send_request(stim_row_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r.rtype;
    row_index_i <= r.row;
    col_index_i <= r.col;
    entry_value_i <= r.val;
    distance_i <= r.dist_val;
    velocity_i <= r.vel;
    do @(posedge clk_i); while (in_stall_o);
    if (r.rtype == REQ_LOAD) grid_shadow[{r.row, r.col}] = r.val;
    else lead_queue.push_back(r.typed ? r.lead : predict_lead(r.dist_val, r.vel));
  endtask

  function automatic stim_row_t rand_request(bit load_only);
    stim_row_t r;
    r.rtype = load_only ? REQ_LOAD : ($urandom_range(3) != 0);
    r.row = 4'($urandom_range(15));
    r.col = 4'($urandom_range(15));
    r.val = 16'($urandom);
    r.typed = 0;
    r.lead = 0;
    // mix full-range values with values near the active grid span
    case ($urandom_range(3))
      0: r.dist_val = 16'($urandom);
      1: r.dist_val = 16'(org_q + $urandom_range(16 * (dstep_q + 1)));
      2: r.dist_val = $urandom_range(1) ? 16'hffff : 16'h0000;
      default: r.dist_val = 16'(dlim_q + $urandom_range(3) - 1);
    endcase
    case ($urandom_range(3))
      0: r.vel = 16'($urandom);
      1: r.vel = 16'($urandom_range(16 * (vstep_q + 1)));
      2: r.vel = $urandom_range(1) ? -16'sh8000 : 16'sh7fff;
      default: r.vel = 16'(-$urandom_range(16 * (vstep_q + 1)));
    endcase
    return r;
  endfunction

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (lead_queue.size() == 0) begin
        $display("%0t: unexpected result lead_value=%0d", $time, lead_value_o);
        fails++;
      end else begin
        if (lead_value_o !== lead_queue[0]) begin
          $display("%0t: lead_value expected %0d actual %0d", $time, lead_queue[0],
                   lead_value_o);
          fails++;
        end
        void'(lead_queue.pop_front());
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    int unsigned fill_order [NPTS*NPTS];
    int unsigned tmp, k;
    stim_row_t r;
    org_q = DIST_ORIGIN_RST;
    dstep_q = DIST_STEP_RST;
    dlim_q = DIST_LIMIT_RST;
    vstep_q = VEL_STEP_RST;
    vfloor_q = VEL_FLOOR_RST;
    vlim_q = VEL_LIMIT_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) send_request(directed[n]);
    drain();

    // Load the whole grid in shuffled order before any random query
    foreach (fill_order[n]) fill_order[n] = n;
    foreach (fill_order[n]) begin
      k = $urandom_range(NPTS * NPTS - 1);
      tmp = fill_order[n];
      fill_order[n] = fill_order[k];
      fill_order[k] = tmp;
    end
    idle_pct = 20;
    stall_pct = 20;
    foreach (fill_order[n]) begin
      r = rand_request(1);
      r.row = fill_order[n][7:4];
      r.col = fill_order[n][3:0];
      send_request(r);
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int g = 0; g < 6; g++) write_reg(cfg_reg_e'(g), reg_sets[p][g]);
      cfg_we_i <= 1'b0;
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 65; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 65; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (140) send_request(rand_request(0));
      drain();
    end

    in_valid_i <= 1'b0;
    while (lead_queue.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/blg_pkg.sv
rtl/blg_ram.sv
rtl/bilinear_grid_lookup_top.sv
tb/bilinear_grid_lookup_top_test.sv
